// ===== hdl/srpq_pkg.sv =====
// Package for the sorted priority request queue.
// Holds the entry type, action codes and cell control struct; depends on nothing.
package srpq_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int PRIO_W = 16;
  localparam int TEX_W  = 10;
  localparam int MIP_W  = 4;
  localparam int HELD_W = 7;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TEX_W-1:0]  tex;
    logic [MIP_W-1:0]  mip;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t ins;
  } cell_ctrl_t;

endpackage

// ===== hdl/srpq_cell.sv =====
// One slot of the sorted queue chain.
// Depends on srpq_pkg for entry_t and cell_ctrl_t.
module srpq_cell
  import srpq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       left_keep,
  input  entry_t     left_data,
  input  entry_t     right_data,
  output entry_t     data,
  output logic       keep
);

  entry_t data_r;
  entry_t data_nxt;

  assign data = data_r;
  assign keep = occupied && (data_r.prio >= ctrl.ins.prio);

  always_comb begin
    data_nxt = data_r;
    priority if (ctrl.push) begin
      if (keep) begin
        data_nxt = data_r;
      end else if (left_keep) begin
        data_nxt = ctrl.ins;
      end else begin
        data_nxt = left_data;
      end
    end else if (ctrl.pop) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== hdl/sorted_priority_request_queue_unit.sv =====
// Top level of the sorted priority request queue: a chain of srpq_cell slots.
// Depends on srpq_pkg and srpq_cell.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   input    | start, busy          | in_action, in_req_tex_slot,
//            |                      | in_req_mip_level, in_req_priority
//   result   | out_strobe           | out_pop_valid, out_tex_slot, out_mip_level,
//            |                      | out_priority, out_push_dropped, out_entries_held
//
// One transaction per cycle while busy is low; its result is registered and shows in the cycle after acceptance.
// Every slot compares against the new priority in parallel and the whole chain shifts at once.
// busy is set by reset and cleared by the first clock edge that sees rst_n high; the fill count resets to zero.
// The receiver cannot stall; each result is held for exactly one cycle.
module sorted_priority_request_queue_unit
  import srpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic [TEX_W-1:0]  in_req_tex_slot,
  input  logic [MIP_W-1:0]  in_req_mip_level,
  input  logic [PRIO_W-1:0] in_req_priority,
  output logic              out_strobe,
  output logic              out_pop_valid,
  output logic [TEX_W-1:0]  out_tex_slot,
  output logic [MIP_W-1:0]  out_mip_level,
  output logic [PRIO_W-1:0] out_priority,
  output logic              out_push_dropped,
  output logic [HELD_W-1:0] out_entries_held
);

  localparam int CW = $clog2(DEPTH + 1);

  logic          busy_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          strobe_r;
  logic          pop_valid_r;
  logic          pop_valid_nxt;
  entry_t        head_r;
  entry_t        head_nxt;
  logic          dropped_r;
  logic          dropped_nxt;

  logic          accept;
  logic          full;
  logic          empty;
  cell_ctrl_t    ctrl;
  logic [CW+HELD_W-1:0] count_ext;

  entry_t        cell_data [DEPTH];
  logic          cell_keep [DEPTH];

  assign accept = start && !busy_r;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  always_comb begin
    ctrl.push     = 1'b0;
    ctrl.pop      = 1'b0;
    ctrl.ins.prio = in_req_priority;
    ctrl.ins.tex  = in_req_tex_slot;
    ctrl.ins.mip  = in_req_mip_level;
    count_nxt     = count_r;
    pop_valid_nxt = 1'b0;
    head_nxt      = '0;
    dropped_nxt   = 1'b0;
    if (accept) begin
      unique case (in_action)
        ACT_PUSH: begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            ctrl.push = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        ACT_POP: begin
          if (!empty) begin
            ctrl.pop      = 1'b1;
            count_nxt     = count_r - CW'(1);
            pop_valid_nxt = 1'b1;
            head_nxt      = cell_data[0];
          end
        end
        ACT_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_data;
    entry_t right_data;
    logic   left_keep;
    logic   occupied;

    assign occupied = (count_r > CW'(i));

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_data = ctrl.ins;
    end else begin : g_mid
      assign left_keep = cell_keep[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    srpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied),
      .left_keep  (left_keep),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .keep       (cell_keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    pop_valid_r <= pop_valid_nxt;
    head_r      <= head_nxt;
    dropped_r   <= dropped_nxt;
  end

  assign count_ext = {{HELD_W{1'b0}}, count_r};

  assign busy              = busy_r;
  assign out_strobe        = strobe_r;
  assign out_pop_valid     = pop_valid_r;
  assign out_tex_slot      = head_r.tex;
  assign out_mip_level     = head_r.mip;
  assign out_priority      = head_r.prio;
  assign out_push_dropped  = dropped_r;
  assign out_entries_held  = count_ext[HELD_W-1:0];

endmodule

// ===== hdl/srpq_checker.sv =====
// Port-level checker for the sorted priority request queue, with its bind.
// Depends on srpq_pkg and sorted_priority_request_queue_unit.
module srpq_checker
  import srpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic              out_pop_valid,
  input logic [TEX_W-1:0]  out_tex_slot,
  input logic [MIP_W-1:0]  out_mip_level,
  input logic [PRIO_W-1:0] out_priority,
  input logic              out_push_dropped,
  input logic [HELD_W-1:0] out_entries_held
);

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (out_strobe == $past(start && !busy)))
    else $error("result strobe does not follow accepted transaction");

  a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_pop_valid && out_push_dropped))
    else $error("pop and drop flagged together");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_pop_valid) |->
      (out_tex_slot == '0 && out_mip_level == '0 && out_priority == '0))
    else $error("fields not zero without a popped request");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_push_dropped) |-> (out_entries_held == HELD_W'(DEPTH)))
    else $error("push dropped while queue not full");

endmodule

bind sorted_priority_request_queue_unit srpq_checker #(.DEPTH(DEPTH)) u_srpq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_pop_valid     (out_pop_valid),
  .out_tex_slot      (out_tex_slot),
  .out_mip_level     (out_mip_level),
  .out_priority      (out_priority),
  .out_push_dropped  (out_push_dropped),
  .out_entries_held  (out_entries_held)
);

// ===== test/tb_sorted_priority_request_queue_unit.sv =====
// Self-checking testbench for sorted_priority_request_queue_unit: a stimulus table
// and random push/pop bursts, checked against a sorted shadow queue.
// Depends on srpq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_sorted_priority_request_queue_unit;
  import srpq_pkg::*;

  localparam int          QDEPTH         = DEPTH_DEF;
  localparam logic [1:0]  ACT_NOP        = 2'd3;
  localparam int          RAND_PER_PHASE = 385;
  localparam int          STALL_LIMIT    = 2000;

  typedef struct packed {
    logic              pop_valid;
    logic [TEX_W-1:0]  tex;
    logic [MIP_W-1:0]  mip;
    logic [PRIO_W-1:0] prio;
    logic              dropped;
    logic [HELD_W-1:0] held;
  } res_t;

  typedef struct {
    logic [1:0]        act;
    logic [TEX_W-1:0]  tex;
    logic [MIP_W-1:0]  mip;
    logic [PRIO_W-1:0] prio;
    int                reps;
    bit                known;
    res_t              want;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_action;
  logic [TEX_W-1:0]  in_req_tex_slot;
  logic [MIP_W-1:0]  in_req_mip_level;
  logic [PRIO_W-1:0] in_req_priority;
  logic              out_strobe;
  logic              out_pop_valid;
  logic [TEX_W-1:0]  out_tex_slot;
  logic [MIP_W-1:0]  out_mip_level;
  logic [PRIO_W-1:0] out_priority;
  logic              out_push_dropped;
  logic [HELD_W-1:0] out_entries_held;

  bit     row_known;
  res_t   row_want;
  entry_t shadow_slots [QDEPTH];
  int     shadow_fill;
  res_t   pending_results [$];
  row_t   stim_table [$];
  int     err_count;
  int     idle_pct;
  int     stall_cycles;

  sorted_priority_request_queue_unit DUT (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic res_t mk_res(input int v, input int t, input int m, input int p,
                                  input int d, input int h);
    res_t r;
    r.pop_valid = 1'(v);
    r.tex       = TEX_W'(t);
    r.mip       = MIP_W'(m);
    r.prio      = PRIO_W'(p);
    r.dropped   = 1'(d);
    r.held      = HELD_W'(h);
    return r;
  endfunction

  task automatic add_row(input logic [1:0] act, input int tex, input int mip, input int prio,
                         input int reps, input int known, input res_t want);
    row_t r;
    r.act   = act;
    r.tex   = TEX_W'(tex);
    r.mip   = MIP_W'(mip);
    r.prio  = PRIO_W'(prio);
    r.reps  = reps;
    r.known = 1'(known);
    r.want  = want;
    stim_table.push_back(r);
  endtask

  task automatic queue_apply(input logic [1:0] act, input logic [TEX_W-1:0] tex,
                             input logic [MIP_W-1:0] mip, input logic [PRIO_W-1:0] prio,
                             output res_t r);
    int     i;
    entry_t head;
    r = '0;
    case (act)
      ACT_PUSH: begin
        if (shadow_fill >= QDEPTH) begin
          r.dropped = 1'b1;
        end else begin
          i = shadow_fill;
          while (i > 0 && shadow_slots[i-1].prio < prio) begin
            shadow_slots[i] = shadow_slots[i-1];
            i--;
          end
          shadow_slots[i].prio = prio;
          shadow_slots[i].tex  = tex;
          shadow_slots[i].mip  = mip;
          shadow_fill++;
        end
      end
      ACT_POP: begin
        if (shadow_fill > 0) begin
          head = shadow_slots[0];
          for (i = 1; i < shadow_fill; i++) shadow_slots[i-1] = shadow_slots[i];
          shadow_fill--;
          r.pop_valid = 1'b1;
          r.tex       = head.tex;
          r.mip       = head.mip;
          r.prio      = head.prio;
        end
      end
      ACT_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    r.held = HELD_W'(shadow_fill);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // check each result against the oldest expectation, then record new transactions
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n) begin
      if (out_strobe) begin
        got.pop_valid = out_pop_valid;
        got.tex       = out_tex_slot;
        got.mip       = out_mip_level;
        got.prio      = out_priority;
        got.dropped   = out_push_dropped;
        got.held      = out_entries_held;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (got.pop_valid !== want.pop_valid)
            report_mismatch($sformatf("pop_valid got %0d want %0d", got.pop_valid,
                                      want.pop_valid));
          if (got.tex !== want.tex)
            report_mismatch($sformatf("tex_slot got %0d want %0d", got.tex, want.tex));
          if (got.mip !== want.mip)
            report_mismatch($sformatf("mip_level got %0d want %0d", got.mip, want.mip));
          if (got.prio !== want.prio)
            report_mismatch($sformatf("priority got %h want %h", got.prio, want.prio));
          if (got.dropped !== want.dropped)
            report_mismatch($sformatf("push_dropped got %0d want %0d", got.dropped,
                                      want.dropped));
          if (got.held !== want.held)
            report_mismatch($sformatf("entries_held got %0d want %0d", got.held, want.held));
        end
      end
      if (start && !busy) begin
        queue_apply(in_action, in_req_tex_slot, in_req_mip_level, in_req_priority,
                    want);
        if (row_known) want = row_want;
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL sorted_priority_request_queue_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_txn(input logic [1:0] act, input logic [TEX_W-1:0] tex,
                          input logic [MIP_W-1:0] mip, input logic [PRIO_W-1:0] prio,
                          input bit known, input res_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_action        <= act;
    in_req_tex_slot  <= tex;
    in_req_mip_level <= mip;
    in_req_priority  <= prio;
    row_known        <= known;
    row_want         <= want;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every outstanding transaction has returned its result
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
  endtask

  function automatic logic [PRIO_W-1:0] pick_prio(input bit ties);
    int r;
    r = $urandom_range(9);
    if (ties || r < 3) return PRIO_W'($urandom_range(3)) * 16'h5555;
    if (r == 3) return PRIO_W'($urandom_range(15));
    return PRIO_W'($urandom);
  endfunction

  initial begin
    int         sent;
    int         mode;
    int         len;
    int         r;
    int         push_th;
    int         pop_th;
    logic [1:0] act;
    row_t       row;

    start            = 1'b0;
    in_action        = ACT_NOP;
    in_req_tex_slot  = '0;
    in_req_mip_level = '0;
    in_req_priority  = '0;
    row_known        = 1'b0;
    row_want         = '0;
    rst_n            = 1'b0;
    shadow_fill      = 0;
    err_count        = 0;
    stall_cycles     = 0;
    idle_pct         = 11;

    add_row(ACT_POP,   0,     0,  0,      1,  1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(ACT_PUSH,  0,     0,  0,      1,  1, mk_res(0, 0, 0, 0, 0, 1));
    add_row(ACT_PUSH,  1023,  15, 'hFFFF, 1,  1, mk_res(0, 0, 0, 0, 0, 2));
    add_row(ACT_PUSH,  5,     3,  'hFFFF, 1,  1, mk_res(0, 0, 0, 0, 0, 3));
    add_row(ACT_PUSH,  7,     9,  'h8000, 1,  1, mk_res(0, 0, 0, 0, 0, 4));
    add_row(ACT_NOP,   'h2AA, 10, 'h5555, 1,  1, mk_res(0, 0, 0, 0, 0, 4));
    add_row(ACT_POP,   'h155, 5,  'hAAAA, 1,  1, mk_res(1, 1023, 15, 'hFFFF, 0, 3));
    add_row(ACT_POP,   0,     0,  0,      1,  1, mk_res(1, 5, 3, 'hFFFF, 0, 2));
    add_row(ACT_POP,   0,     0,  0,      1,  0, '0);
    add_row(ACT_POP,   0,     0,  0,      1,  0, '0);
    add_row(ACT_POP,   1023,  15, 'hFFFF, 1,  1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(ACT_PUSH,  100,   1,  'h1234, 1,  0, '0);
    add_row(ACT_PUSH,  101,   2,  'h1234, 1,  0, '0);
    add_row(ACT_PUSH,  102,   3,  'h1234, 1,  0, '0);
    add_row(ACT_PUSH,  200,   4,  'h1235, 1,  0, '0);
    add_row(ACT_POP,   0,     0,  0,      1,  0, '0);
    add_row(ACT_POP,   0,     0,  0,      1,  0, '0);
    add_row(ACT_CLEAR, 'h155, 5,  'hAAAA, 1,  1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(ACT_POP,   0,     0,  0,      1,  1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(ACT_PUSH,  300,   6,  'h0100, 64, 0, '0);
    add_row(ACT_PUSH,  999,   12, 'hFFFF, 1,  1, mk_res(0, 0, 0, 0, 1, 64));
    add_row(ACT_POP,   0,     0,  0,      1,  0, '0);
    add_row(ACT_PUSH,  512,   8,  0,      1,  0, '0);
    add_row(ACT_PUSH,  1,     1,  1,      1,  1, mk_res(0, 0, 0, 0, 1, 64));
    add_row(ACT_CLEAR, 0,     0,  0,      1,  1, mk_res(0, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      for (int k = 0; k < row.reps; k++)
        send_txn(row.act, row.tex ^ TEX_W'(k), row.mip, row.prio + PRIO_W'(k * 1031),
                 row.known, row.want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 11 : (ph == 1) ? 68 : 0;
      drain_results();
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        mode = $urandom_range(9);
        len  = $urandom_range(1, 80);
        case (mode)
          4, 5:    begin push_th = 94; pop_th = 98; end
          6, 7:    begin push_th = 9;  pop_th = 97; end
          default: begin push_th = 52; pop_th = 95; end
        endcase
        for (int k = 0; k < len && sent < RAND_PER_PHASE; k++) begin
          r = $urandom_range(99);
          if (mode == 8 && k == 0) act = ACT_CLEAR;
          else if (r < push_th)    act = ACT_PUSH;
          else if (r < pop_th)     act = ACT_POP;
          else if (r < 98)         act = ACT_NOP;
          else                     act = ACT_CLEAR;
          if ($urandom_range(199) == 0) drain_results();
          send_txn(act, TEX_W'($urandom), MIP_W'($urandom), pick_prio(mode == 9), 1'b0, '0);
          if (act != ACT_NOP) sent++;
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("PASS sorted_priority_request_queue_unit");
    end else begin
      $display("FAIL sorted_priority_request_queue_unit");
    end
    $finish;
  end

endmodule
